[sv/pcsd_pkg.sv]
package pcsd_pkg;

    localparam int TABLE_DEPTH  = 256;
    localparam int MAX_CODE_LEN = 32;
    localparam int PEND_CAP     = MAX_CODE_LEN + 8;
    localparam int RES_MAX      = 8;

    localparam int TBL_AW = $clog2(TABLE_DEPTH);
    localparam int ECNT_W = 9;
    localparam int PAD_W  = 3;
    localparam int LEN_W  = 6;
    localparam int CODE_W = 32;
    localparam int SYM_W  = 8;
    localparam int IDX_W  = 8;
    localparam int BYTE_W = 8;
    localparam int REQ_W  = 2;
    localparam int PCNT_W = $clog2(PEND_CAP + 1);
    localparam int CW     = (PCNT_W > LEN_W ? PCNT_W : LEN_W) + 1;
    localparam int RES_W  = $clog2(RES_MAX + 1);

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DATA  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_START = 2'd2;

    typedef struct packed {
        logic [SYM_W-1:0]  sym;
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] bits;
    } t_entry;

    typedef struct packed {
        logic              vld;
        logic [REQ_W-1:0]  req_type;
        logic [IDX_W-1:0]  entry_index;
        t_entry            entry;
        logic [BYTE_W-1:0] data_byte;
    } t_req;

    typedef struct packed {
        logic             vld;
        logic             last;
        logic [SYM_W-1:0] sym;
    } t_push;

    // ones in the low w bits
    function automatic logic [PEND_CAP-1:0] low_mask(input logic [CW-1:0] w);
        logic [PEND_CAP:0] one_sh;
        one_sh = (PEND_CAP + 1)'(1) << w;
        return one_sh[PEND_CAP-1:0] - PEND_CAP'(1);
    endfunction

endpackage

[sv/prefix_code_stream_decoder.sv]
// Load and start words: accepted back to back, one per cycle, no result.
// Data word: busy while the table is rescanned from entry 0 for each match,
//   up to 8 matches over up to 256 searched entries.
// Table scan: one entry per cycle through the single read port and match unit
// while output is free; a result is held until the next match or scan end.
// Synchronous active-low reset: stream idle, pending bits cleared, padding armed.
module prefix_code_stream_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] entry_index, [15:8] entry_symbol, [21:16] entry_code_len,
    // [53:22] entry_code_bits, [61:54] data_byte, [63:62] zero
    input  logic [63:0] s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] symbol
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_LEAD_PAD    = 1'b1;

    logic [pcsd_pkg::ECNT_W-1:0] r_entry_count;
    logic [pcsd_pkg::PAD_W-1:0]  r_lead_pad;
    logic                        r_m_vld;
    logic                        r_m_last;
    logic [pcsd_pkg::SYM_W-1:0]  r_m_sym;
    pcsd_pkg::t_req              req;
    pcsd_pkg::t_push             push;
    logic                        push_rdy;
    logic                        core_ready;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= pcsd_pkg::ECNT_W'(256);
            r_lead_pad    <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[2])
                REG_ENTRY_COUNT: r_entry_count <= pwdata[pcsd_pkg::ECNT_W-1:0];
                REG_LEAD_PAD:    r_lead_pad    <= pwdata[pcsd_pkg::PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_ENTRY_COUNT: prdata = 32'(r_entry_count);
            REG_LEAD_PAD:    prdata = 32'(r_lead_pad);
            default:         prdata = '0;
        endcase
    end

    assign req.vld         = s_axis_tvalid;
    assign req.req_type    = s_axis_tuser;
    assign req.entry_index = s_axis_tdata[7:0];
    assign req.entry.sym   = s_axis_tdata[15:8];
    assign req.entry.len   = s_axis_tdata[21:16];
    assign req.entry.bits  = s_axis_tdata[53:22];
    assign req.data_byte   = s_axis_tdata[61:54];

    assign s_axis_tready = core_ready;

    pcsd_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req),
        .o_ready       (core_ready),
        .i_entry_count (r_entry_count),
        .i_lead_pad    (r_lead_pad),
        .o_push        (push),
        .i_push_rdy    (push_rdy)
    );

    assign push_rdy = !r_m_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (push.vld && push_rdy) begin
            r_m_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push.vld && push_rdy) begin
            r_m_sym  <= push.sym;
            r_m_last <= push.last;
        end
    end

    assign m_axis_tvalid = r_m_vld;
    assign m_axis_tdata  = r_m_sym;
    assign m_axis_tlast  = r_m_last;

endmodule

[sv/pcsd_table.sv]
module pcsd_table (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [pcsd_pkg::TBL_AW-1:0] i_wr_addr,
    input  pcsd_pkg::t_entry            i_wr_data,
    input  logic                        i_rd_en,
    input  logic [pcsd_pkg::TBL_AW-1:0] i_rd_addr,
    output pcsd_pkg::t_entry            o_rd_data
);

    pcsd_pkg::t_entry r_mem [pcsd_pkg::TABLE_DEPTH];
    pcsd_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/pcsd_core.sv]
module pcsd_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pcsd_pkg::t_req              i_req,
    output logic                        o_ready,
    input  logic [pcsd_pkg::ECNT_W-1:0] i_entry_count,
    input  logic [pcsd_pkg::PAD_W-1:0]  i_lead_pad,
    output pcsd_pkg::t_push             o_push,
    input  logic                        i_push_rdy
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]                          r_state, n_state;
    logic [pcsd_pkg::PEND_CAP-1:0]       r_bits, n_bits;
    logic [pcsd_pkg::PCNT_W-1:0]         r_cnt, n_cnt;
    logic                                r_armed, n_armed;
    logic [pcsd_pkg::ECNT_W-1:0]         r_rd_idx, n_rd_idx;
    logic                                r_cmp_vld, n_cmp_vld;
    logic [pcsd_pkg::RES_W-1:0]          r_res, n_res;
    logic                                r_hold_vld, n_hold_vld;
    logic [pcsd_pkg::SYM_W-1:0]          r_hold_sym, n_hold_sym;

    pcsd_pkg::t_entry                    ent;
    logic                                wr_en;
    logic                                rd_en;
    logic [pcsd_pkg::ECNT_W-1:0]         limit;
    logic [pcsd_pkg::CW-1:0]             len_w, cnt_w, rem_cnt;
    logic [pcsd_pkg::CW-1:0]             app_cnt, sat_cnt;
    logic [pcsd_pkg::PEND_CAP-1:0]       msk, head, code, app_bits;
    logic                                len_ok, hit;

    pcsd_table u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_req.entry_index[pcsd_pkg::TBL_AW-1:0]),
        .i_wr_data (i_req.entry),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_rd_idx[pcsd_pkg::TBL_AW-1:0]),
        .o_rd_data (ent)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign wr_en   = o_ready && i_req.vld && (i_req.req_type == pcsd_pkg::REQ_LOAD)
                     && (pcsd_pkg::ECNT_W'(i_req.entry_index)
                         < pcsd_pkg::ECNT_W'(pcsd_pkg::TABLE_DEPTH));

    assign limit = (i_entry_count > pcsd_pkg::ECNT_W'(pcsd_pkg::TABLE_DEPTH))
                   ? pcsd_pkg::ECNT_W'(pcsd_pkg::TABLE_DEPTH) : i_entry_count;

    // shared match unit: one entry against the head of the pending bits
    assign len_w   = pcsd_pkg::CW'(ent.len);
    assign cnt_w   = pcsd_pkg::CW'(r_cnt);
    assign len_ok  = (ent.len != '0) && (len_w <= pcsd_pkg::CW'(pcsd_pkg::MAX_CODE_LEN))
                     && (len_w <= cnt_w);
    assign rem_cnt = cnt_w - len_w;
    assign msk     = pcsd_pkg::low_mask(len_w);
    assign head    = (r_bits >> rem_cnt) & msk;
    assign code    = pcsd_pkg::PEND_CAP'(ent.bits) & msk;
    assign hit     = r_cmp_vld && len_ok && (head == code);

    // byte append
    assign app_cnt  = cnt_w + pcsd_pkg::CW'(8)
                      - (r_armed ? pcsd_pkg::CW'(i_lead_pad) : pcsd_pkg::CW'(0));
    assign sat_cnt  = (app_cnt > pcsd_pkg::CW'(pcsd_pkg::PEND_CAP))
                      ? pcsd_pkg::CW'(pcsd_pkg::PEND_CAP) : app_cnt;
    assign app_bits = pcsd_pkg::PEND_CAP'({r_bits, i_req.data_byte})
                      & pcsd_pkg::low_mask(sat_cnt);

    always_comb begin
        n_state    = r_state;
        n_bits     = r_bits;
        n_cnt      = r_cnt;
        n_armed    = r_armed;
        n_rd_idx   = r_rd_idx;
        n_cmp_vld  = r_cmp_vld;
        n_res      = r_res;
        n_hold_vld = r_hold_vld;
        n_hold_sym = r_hold_sym;
        rd_en      = 1'b0;
        o_push     = '0;
        o_push.sym = r_hold_sym;

        case (r_state)
            ST_IDLE: begin
                if (i_req.vld) begin
                    case (i_req.req_type)
                        pcsd_pkg::REQ_START: begin
                            n_bits  = '0;
                            n_cnt   = '0;
                            n_armed = 1'b1;
                        end
                        pcsd_pkg::REQ_DATA: begin
                            n_bits     = app_bits;
                            n_cnt      = pcsd_pkg::PCNT_W'(sat_cnt);
                            n_armed    = 1'b0;
                            n_rd_idx   = '0;
                            n_cmp_vld  = 1'b0;
                            n_res      = '0;
                            n_hold_vld = 1'b0;
                            n_state    = ST_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (hit) begin
                    if (!r_hold_vld || i_push_rdy) begin
                        o_push.vld = r_hold_vld;
                        n_hold_vld = 1'b1;
                        n_hold_sym = ent.sym;
                        n_res      = r_res + pcsd_pkg::RES_W'(1);
                        n_cnt      = pcsd_pkg::PCNT_W'(rem_cnt);
                        n_bits     = r_bits & pcsd_pkg::low_mask(rem_cnt);
                        n_rd_idx   = '0;
                        n_cmp_vld  = 1'b0;
                    end
                end else if (!r_cmp_vld && ((r_cnt == '0)
                             || (r_res == pcsd_pkg::RES_W'(pcsd_pkg::RES_MAX))
                             || (r_rd_idx >= limit))) begin
                    n_state = ST_FIN;
                end else if (r_rd_idx < limit) begin
                    rd_en     = 1'b1;
                    n_rd_idx  = r_rd_idx + pcsd_pkg::ECNT_W'(1);
                    n_cmp_vld = 1'b1;
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end
            ST_FIN: begin
                if (r_hold_vld) begin
                    o_push.vld  = 1'b1;
                    o_push.last = 1'b1;
                    if (i_push_rdy) begin
                        n_hold_vld = 1'b0;
                        n_state    = ST_IDLE;
                    end
                end else begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_bits     <= '0;
            r_cnt      <= '0;
            r_armed    <= 1'b1;
            r_rd_idx   <= '0;
            r_cmp_vld  <= 1'b0;
            r_res      <= '0;
            r_hold_vld <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_bits     <= n_bits;
            r_cnt      <= n_cnt;
            r_armed    <= n_armed;
            r_rd_idx   <= n_rd_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_res      <= n_res;
            r_hold_vld <= n_hold_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hold_sym <= n_hold_sym;
    end

endmodule

[sv/pcsd_checker.sv]
module pcsd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    a_data_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == pcsd_pkg::REQ_DATA)
            |=> !s_axis_tready)
        else $error("ready after data word without decode pass");

    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input taken while a run is still open");

    a_ctrl_no_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser != pcsd_pkg::REQ_DATA)
            && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result after a non-data word");

endmodule

bind prefix_code_stream_decoder pcsd_checker u_pcsd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [pcsd_pkg::REQ_W-1:0] REQ_UNKNOWN = 2'd3;
    localparam logic [2:0] ADDR_ENTRY_COUNT = 3'd0;
    localparam logic [2:0] ADDR_LEAD_PAD    = 3'd4;
    localparam int SETTLE_CYC = 2400;
    localparam int DRAIN_MAX  = 100000;
    localparam int N_DIR      = 26;

    typedef enum logic [2:0] {TBL_BIT1, TBL_NIB, TBL_UNARY, TBL_MIXED, TBL_WIDE} t_tbl_kind;

    typedef struct packed {
        logic [pcsd_pkg::SYM_W-1:0] sym;
        logic                       last;
    } t_sym_exp;

    typedef struct packed {
        logic [pcsd_pkg::REQ_W-1:0]  req;
        logic [pcsd_pkg::IDX_W-1:0]  idx;
        logic [pcsd_pkg::SYM_W-1:0]  sym;
        logic [pcsd_pkg::LEN_W-1:0]  len;
        logic [pcsd_pkg::CODE_W-1:0] bits;
        logic [pcsd_pkg::BYTE_W-1:0] dbyte;
        logic                        typed;
        logic [3:0]                  n_out;
        logic [pcsd_pkg::SYM_W-1:0]  esym;
    } t_dir_row;

    // entry_count 4, lead_padding 3 during this table
    localparam t_dir_row DIR_ROWS [N_DIR] = '{
        '{pcsd_pkg::REQ_LOAD,  8'd0,   8'h41, 6'd1,  32'hFFFF_FFFE, 8'h00, 1'b0, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_LOAD,  8'd1,   8'h42, 6'd2,  32'h0000_0002, 8'h00, 1'b0, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_LOAD,  8'd2,   8'h43, 6'd0,  32'h0000_0003, 8'h00, 1'b0, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_LOAD,  8'd3,   8'h44, 6'd2,  32'h0000_0003, 8'h00, 1'b0, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd5, 8'h41},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'hFF, 1'b1, 4'd4, 8'h44},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h55, 1'b0, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_START, 8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'hE0, 1'b1, 4'd5, 8'h41},
        '{REQ_UNKNOWN,         8'hFF,  8'hFF, 6'h3F, 32'hFFFF_FFFF, 8'hFF, 1'b1, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd8, 8'h41},
        '{pcsd_pkg::REQ_LOAD,  8'd0,   8'h30, 6'd33, 32'h0000_0000, 8'h00, 1'b0, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_LOAD,  8'd0,   8'h31, 6'd32, 32'h0000_0000, 8'h00, 1'b0, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd1, 8'h31},
        '{pcsd_pkg::REQ_LOAD,  8'd255, 8'hFF, 6'd63, 32'hFFFF_FFFF, 8'h00, 1'b0, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_LOAD,  8'd3,   8'h44, 6'd0,  32'h0000_0003, 8'h00, 1'b0, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_LOAD,  8'd1,   8'hEE, 6'd32, 32'hFFFF_FFFF, 8'h00, 1'b0, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'hFF, 1'b1, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd0, 8'h00},
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd0, 8'h00},
        // pending saturates here, the leading ones fall out
        '{pcsd_pkg::REQ_DATA,  8'd0,   8'h00, 6'd0,  32'h0000_0000, 8'h00, 1'b1, 4'd1, 8'h31}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // [7:0] entry_index, [15:8] entry_symbol, [21:16] entry_code_len,
    // [53:22] entry_code_bits, [61:54] data_byte, [63:62] zero
    logic [63:0] s_axis_tdata = '0;
    // [1:0] req_type
    logic [1:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [7:0] symbol
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    // decoder mirror
    pcsd_pkg::t_entry dec_table [pcsd_pkg::TABLE_DEPTH];
    logic [63:0]      acc_bits;
    int unsigned      acc_cnt;
    bit               pad_armed;
    int unsigned      cfg_entries;
    int unsigned      cfg_pad;

    t_sym_exp    sym_exp_q [$];
    int          errors = 0;
    int unsigned words_in = 0;
    int unsigned syms_out = 0;
    int unsigned run_ends = 0;
    int unsigned reg_writes = 0;
    bit          calm = 1'b0;

    prefix_code_stream_decoder u_dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [63:0] ones(input int unsigned n);
        return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
    endfunction

    function automatic logic [63:0] pack_word(input logic [7:0] idx, input logic [7:0] sym,
                                              input logic [5:0] len, input logic [31:0] bits,
                                              input logic [7:0] dbyte);
        return {2'b00, dbyte, bits, len, sym, idx};
    endfunction

    // advance the mirror by one accepted word, queue the symbols it yields if keep is set
    function automatic void predict_word(input logic [1:0] req, input logic [63:0] w,
                                         input bit keep);
        int unsigned lim, l, i, n_hit;
        int          hit;
        t_sym_exp    fresh [$];
        case (req)
            pcsd_pkg::REQ_LOAD: begin
                dec_table[w[7:0]] = {w[15:8], w[21:16], w[53:22]};
            end
            pcsd_pkg::REQ_START: begin
                acc_bits  = '0;
                acc_cnt   = 0;
                pad_armed = 1'b1;
            end
            pcsd_pkg::REQ_DATA: begin
                acc_bits = (acc_bits << 8) | 64'(w[61:54]);
                acc_cnt += 8;
                if (pad_armed) begin
                    acc_cnt  -= cfg_pad;
                    pad_armed = 1'b0;
                end
                if (acc_cnt > pcsd_pkg::PEND_CAP)
                    acc_cnt = pcsd_pkg::PEND_CAP;
                acc_bits &= ones(acc_cnt);
                lim   = (cfg_entries < pcsd_pkg::TABLE_DEPTH) ? cfg_entries
                                                             : pcsd_pkg::TABLE_DEPTH;
                n_hit = 0;
                while (n_hit < pcsd_pkg::RES_MAX && acc_cnt > 0) begin
                    hit = -1;
                    for (i = 0; i < lim; i++) begin
                        l = 32'(dec_table[i].len);
                        if (hit < 0 && l != 0 && l <= pcsd_pkg::MAX_CODE_LEN && l <= acc_cnt &&
                            ((acc_bits >> (acc_cnt - l)) & ones(l)) ==
                            (64'(dec_table[i].bits) & ones(l)))
                            hit = i;
                    end
                    if (hit < 0)
                        break;
                    fresh.push_back('{sym: dec_table[hit].sym, last: 1'b0});
                    acc_cnt -= 32'(dec_table[hit].len);
                    acc_bits &= ones(acc_cnt);
                    n_hit++;
                end
                if (n_hit > 0)
                    fresh[n_hit-1].last = 1'b1;
                if (keep)
                    foreach (fresh[m])
                        sym_exp_q.push_back(fresh[m]);
            end
            default: ;
        endcase
    endfunction

    function automatic pcsd_pkg::t_entry make_entry(input t_tbl_kind kind,
                                                    input int unsigned idx,
                                                    input int unsigned lim);
        pcsd_pkg::t_entry e;
        e.sym  = 8'($urandom);
        e.bits = $urandom;
        case (kind)
            TBL_BIT1: begin
                e.len     = 6'd1;
                e.bits[0] = idx[0];
            end
            TBL_NIB: begin
                e.len       = 6'd4;
                e.bits[3:0] = idx[3:0];
            end
            TBL_UNARY: begin
                // 1, 01, 001, ... closed by an all-zero word of the same length
                if (idx + 1 < lim) begin
                    e.len  = (idx + 1 > 63) ? 6'd63 : 6'(idx + 1);
                    e.bits = 32'd1;
                end else begin
                    e.len  = (idx > 63) ? 6'd63 : 6'(idx);
                    e.bits = 32'd0;
                end
            end
            TBL_MIXED: begin
                e.len = 6'($urandom_range(1, 8));
                if ($urandom_range(0, 7) == 0)
                    e.len = 6'($urandom_range(0, 63));
            end
            default: begin
                e.len = 6'($urandom_range(1, 12));
                case ($urandom_range(0, 9))
                    0: e.len = 6'd0;
                    1: e.len = 6'($urandom_range(33, 63));
                    2: e.len = 6'd32;
                    default: ;
                endcase
            end
        endcase
        return e;
    endfunction

    task automatic push_word(input logic [1:0] req, input logic [63:0] w, input bit keep);
        if (!calm)
            while ($urandom_range(0, 99) < 35) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= w;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        words_in++;
        predict_word(req, w, keep);
    endtask

    task automatic drain_results();
        int unsigned spin;
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        spin = 0;
        while (sym_exp_q.size() != 0 && spin < DRAIN_MAX) begin
            @(posedge i_clk);
            spin++;
        end
        if (sym_exp_q.size() != 0) begin
            $error("%0d expected symbols never arrived", sym_exp_q.size());
            errors++;
            sym_exp_q.delete();
        end
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do
            @(posedge i_clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_ENTRY_COUNT)
            cfg_entries = val & 32'h1FF;
        else if (addr == ADDR_LEAD_PAD)
            cfg_pad = val & 32'h7;
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [8:0] ec, input logic [2:0] pad,
                             input t_tbl_kind kind, input int unsigned n_items,
                             input bit quiet, input bit fill);
        int unsigned      lim, k, ix, r;
        pcsd_pkg::t_entry e;
        logic [63:0]      w;
        apb_write(ADDR_ENTRY_COUNT, 32'(ec));
        apb_write(ADDR_LEAD_PAD, 32'(pad));
        calm = quiet;
        lim  = (ec < pcsd_pkg::TABLE_DEPTH) ? ec : pcsd_pkg::TABLE_DEPTH;
        // every searched slot is written before any data word, here or by an earlier phase
        if (fill)
            for (k = 0; k < lim; k++) begin
                e = make_entry(kind, k, lim);
                push_word(pcsd_pkg::REQ_LOAD,
                          pack_word(k[7:0], e.sym, e.len, e.bits, 8'($urandom)), 1'b1);
            end
        for (k = 0; k < n_items; k++) begin
            if (k == n_items / 2)
                drain_results();
            w = {$urandom, $urandom};
            w[63:62] = 2'b00;
            r = $urandom_range(0, 99);
            if (r < 68) begin
                push_word(pcsd_pkg::REQ_DATA, w, 1'b1);
            end else if (r < 83) begin
                if (lim == 0 || $urandom_range(0, 1) == 1)
                    ix = $urandom_range(0, 255);
                else
                    ix = $urandom_range(0, lim - 1);
                if ($urandom_range(0, 3) != 0) begin
                    e = make_entry(kind, ix, lim);
                    w = pack_word(ix[7:0], e.sym, e.len, e.bits, w[61:54]);
                end else begin
                    w[7:0] = ix[7:0];
                end
                push_word(pcsd_pkg::REQ_LOAD, w, 1'b1);
            end else if (r < 94) begin
                push_word(pcsd_pkg::REQ_START, w, 1'b1);
            end else begin
                push_word(REQ_UNKNOWN, w, 1'b1);
            end
        end
        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        calm = 1'b0;
    endtask

    always @(posedge i_clk) begin : rx_side
        t_sym_exp e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            syms_out++;
            if (m_axis_tlast)
                run_ends++;
            if (sym_exp_q.size() == 0) begin
                $error("symbol %02h arrived with none expected", m_axis_tdata);
                errors++;
            end else begin
                e = sym_exp_q.pop_front();
                if (m_axis_tdata !== e.sym) begin
                    $error("symbol: expected %02h, got %02h", e.sym, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_of_run: expected %0b, got %0b", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
        m_axis_tready <= calm || ($urandom_range(0, 99) >= 35);
    end

    initial begin : stim
        int       k, j;
        t_dir_row row;
        for (k = 0; k < pcsd_pkg::TABLE_DEPTH; k++)
            dec_table[k] = '0;
        acc_bits    = '0;
        acc_cnt     = 0;
        pad_armed   = 1'b1;
        cfg_entries = 256;
        cfg_pad     = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        apb_write(ADDR_ENTRY_COUNT, 32'd4);
        apb_write(ADDR_LEAD_PAD, 32'd3);
        for (k = 0; k < N_DIR; k++) begin
            row = DIR_ROWS[k];
            push_word(row.req, pack_word(row.idx, row.sym, row.len, row.bits, row.dbyte),
                      !row.typed);
            if (row.typed)
                for (j = 0; j < row.n_out; j++)
                    sym_exp_q.push_back('{sym: row.esym, last: (j == row.n_out - 1)});
        end
        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);

        run_phase(9'd2,   3'd7, TBL_BIT1,  16, 1'b0, 1'b1);
        run_phase(9'd8,   3'd0, TBL_NIB,   12, 1'b1, 1'b1);
        run_phase(9'd9,   3'd5, TBL_UNARY, 12, 1'b0, 1'b1);
        run_phase(9'd12,  3'd2, TBL_MIXED, 12, 1'b0, 1'b1);
        run_phase(9'd0,   3'd1, TBL_MIXED, 6,  1'b0, 1'b1);
        run_phase(9'd256, 3'd6, TBL_WIDE,  10, 1'b0, 1'b1);
        run_phase(9'd511, 3'd4, TBL_WIDE,  6,  1'b0, 1'b0);
        run_phase(9'd1,   3'd3, TBL_BIT1,  6,  1'b0, 1'b1);

        $display("run: %0d words in, %0d symbols out, %0d run ends, %0d register writes",
                 words_in, syms_out, run_ends, reg_writes);
        $display("tables: 1-bit, 4-bit, unary, mixed, wide; entry counts 0..511, padding 0..7");
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

[filelist.f]
sv/pcsd_pkg.sv
sv/pcsd_table.sv
sv/pcsd_core.sv
sv/prefix_code_stream_decoder.sv
sv/pcsd_checker.sv
tb/tb_top.sv
